/* design/u8va_pkg.sv */
// Shared types, constants and the code point lookup for the UTF-8 to ASCII block.
// Used by u8va_decode and utf8_vietnamese_to_ascii; depends on nothing else.
`default_nettype none

package u8va_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned PEND_W  = 2;

  localparam logic [7:0] UNKNOWN_CHAR  = 8'h3F;
  localparam logic [7:0] ASCII_LIMIT   = 8'h80;
  localparam logic [7:0] LEAD2_MASK    = 8'hE0;
  localparam logic [7:0] LEAD2_CODE    = 8'hC0;
  localparam logic [7:0] LEAD3_MASK    = 8'hF0;
  localparam logic [7:0] LEAD3_CODE    = 8'hE0;
  localparam logic [7:0] LEAD4_MASK    = 8'hF8;
  localparam logic [7:0] LEAD4_CODE    = 8'hF0;
  localparam logic [7:0] CONT_MASK     = 8'hC0;
  localparam logic [7:0] CONT_CODE     = 8'h80;

  // Register index of the enable register in the config space
  localparam logic REG_ENABLE = 1'b0;

  // Decoder state carried from one beat to the next
  typedef struct packed {
    logic [PEND_W-1:0] pend;
    logic [CP_W-1:0]   accum;
  } dec_state_t;

  // What one beat produces
  typedef struct packed {
    logic       emit;
    logic [7:0] ch;
  } dec_result_t;

  function automatic logic [7:0] map_code_point(input logic [CP_W-1:0] cp);
    logic [7:0] ch;
    ch = UNKNOWN_CHAR;
    if (cp < CP_W'(ASCII_LIMIT)) begin
      ch = cp[7:0];
    end else begin
      unique case (cp)
        21'h0111: ch = "d";
        21'h0110: ch = "D";
        21'h00E1, 21'h00E0, 21'h1EA3, 21'h00E3, 21'h1EA1, 21'h0103, 21'h1EAF,
        21'h1EB1, 21'h1EB3, 21'h1EB5, 21'h1EB7, 21'h00E2, 21'h1EA5, 21'h1EA7,
        21'h1EA9, 21'h1EAB, 21'h1EAD: ch = "a";
        21'h00C1, 21'h00C0, 21'h1EA2, 21'h00C3, 21'h1EA0, 21'h0102, 21'h1EAE,
        21'h1EB0, 21'h1EB2, 21'h1EB4, 21'h1EB6, 21'h00C2, 21'h1EA4, 21'h1EA6,
        21'h1EA8, 21'h1EAA, 21'h1EAC: ch = "A";
        21'h00E9, 21'h00E8, 21'h1EBB, 21'h1EBD, 21'h1EB9, 21'h00EA, 21'h1EBF,
        21'h1EC1, 21'h1EC3, 21'h1EC5, 21'h1EC7: ch = "e";
        21'h00C9, 21'h00C8, 21'h1EBA, 21'h1EBC, 21'h1EB8, 21'h00CA, 21'h1EBE,
        21'h1EC0, 21'h1EC2, 21'h1EC4, 21'h1EC6: ch = "E";
        21'h00ED, 21'h00EC, 21'h1EC9, 21'h0129, 21'h1ECB: ch = "i";
        21'h00CD, 21'h00CC, 21'h1EC8, 21'h0128, 21'h1ECA: ch = "I";
        21'h00F3, 21'h00F2, 21'h1ECF, 21'h00F5, 21'h1ECD, 21'h00F4, 21'h1ED1,
        21'h1ED3, 21'h1ED5, 21'h1ED7, 21'h1ED9, 21'h01A1, 21'h1EDB, 21'h1EDD,
        21'h1EDF, 21'h1EE1, 21'h1EE3, 21'h00B0, 21'h00BA: ch = "o";
        21'h00D3, 21'h00D2, 21'h1ECE, 21'h00D5, 21'h1ECC, 21'h00D4, 21'h1ED0,
        21'h1ED2, 21'h1ED4, 21'h1ED6, 21'h1ED8, 21'h01A0, 21'h1EDA, 21'h1EDC,
        21'h1EDE, 21'h1EE0, 21'h1EE2: ch = "O";
        21'h00FA, 21'h00F9, 21'h1EE7, 21'h0169, 21'h1EE5, 21'h01B0, 21'h1EE9,
        21'h1EEB, 21'h1EED, 21'h1EEF, 21'h1EF1, 21'h00B5, 21'h03BC: ch = "u";
        21'h00DA, 21'h00D9, 21'h1EE6, 21'h0168, 21'h1EE4, 21'h01AF, 21'h1EE8,
        21'h1EEA, 21'h1EEC, 21'h1EEE, 21'h1EF0: ch = "U";
        21'h00FD, 21'h1EF3, 21'h1EF7, 21'h1EF9, 21'h1EF5: ch = "y";
        21'h00DD, 21'h1EF2, 21'h1EF6, 21'h1EF8, 21'h1EF4: ch = "Y";
        21'h2103: ch = "C";
        21'h2109: ch = "F";
        21'h00D7: ch = "x";
        21'h00F7: ch = "/";
        21'h2192: ch = ">";
        21'h2190: ch = "<";
        21'h2013, 21'h2014: ch = "-";
        21'h201C, 21'h201D: ch = "\"";
        21'h2018, 21'h2019: ch = "'";
        21'h2026: ch = ".";
        default: ch = UNKNOWN_CHAR;
      endcase
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

/* design/u8va_decode.sv */
// Next-state and result logic of the UTF-8 decoder for one byte.
// Depends on u8va_pkg (state/result structs, lead byte codes, lookup function).
`default_nettype none

module u8va_decode (
  input  wire logic                  en,
  input  wire logic [7:0]            byte_in,
  input  wire logic                  last,
  input  wire u8va_pkg::dec_state_t  state,
  output u8va_pkg::dec_state_t       state_nxt,
  output u8va_pkg::dec_result_t      result
);

  logic                        is_cont;
  logic [u8va_pkg::CP_W-1:0]   accum_shift;
  logic [u8va_pkg::PEND_W-1:0] pend_dec;

  assign is_cont     = (byte_in & u8va_pkg::CONT_MASK) == u8va_pkg::CONT_CODE;
  assign accum_shift = {state.accum[u8va_pkg::CP_W-7:0], byte_in[5:0]};
  assign pend_dec    = state.pend - u8va_pkg::PEND_W'(1);

  always_comb begin
    state_nxt  = state;
    result.emit = 1'b0;
    result.ch   = u8va_pkg::UNKNOWN_CHAR;
    if (!en) begin
      // raw pass-through, drop any partial sequence
      state_nxt   = '0;
      result.emit = 1'b1;
      result.ch   = byte_in;
    end else if (state.pend == '0) begin
      if (byte_in < u8va_pkg::ASCII_LIMIT) begin
        result.emit = 1'b1;
        result.ch   = byte_in;
      end else if ((byte_in & u8va_pkg::LEAD2_MASK) == u8va_pkg::LEAD2_CODE ||
                   (byte_in & u8va_pkg::LEAD3_MASK) == u8va_pkg::LEAD3_CODE ||
                   (byte_in & u8va_pkg::LEAD4_MASK) == u8va_pkg::LEAD4_CODE) begin
        if (last) begin
          state_nxt   = '0;
          result.emit = 1'b1;
        end else if ((byte_in & u8va_pkg::LEAD2_MASK) == u8va_pkg::LEAD2_CODE) begin
          state_nxt.pend  = u8va_pkg::PEND_W'(1);
          state_nxt.accum = u8va_pkg::CP_W'(byte_in[4:0]);
        end else if ((byte_in & u8va_pkg::LEAD3_MASK) == u8va_pkg::LEAD3_CODE) begin
          state_nxt.pend  = u8va_pkg::PEND_W'(2);
          state_nxt.accum = u8va_pkg::CP_W'(byte_in[3:0]);
        end else begin
          state_nxt.pend  = u8va_pkg::PEND_W'(3);
          state_nxt.accum = u8va_pkg::CP_W'(byte_in[2:0]);
        end
      end
      // stray continuation or invalid lead: drop, state unchanged
    end else if (!is_cont) begin
      state_nxt   = '0;
      result.emit = 1'b1;
    end else if (pend_dec == '0) begin
      state_nxt   = '0;
      result.emit = 1'b1;
      result.ch   = u8va_pkg::map_code_point(accum_shift);
    end else if (last) begin
      state_nxt   = '0;
      result.emit = 1'b1;
    end else begin
      state_nxt.pend  = pend_dec;
      state_nxt.accum = accum_shift;
    end
  end

endmodule

`default_nettype wire

/* design/utf8_vietnamese_to_ascii.sv */
// Top level of the UTF-8 to ASCII transliterator: handshake pipeline and APB registers.
// Depends on u8va_pkg and u8va_decode.
`default_nettype none

// Decodes a UTF-8 byte stream, one byte per beat, into single ASCII characters.
// Bytes below 0x80 pass through; a complete two-, three- or four-byte sequence
// produces one character from the Vietnamese/symbol table, or '?' if the code
// point is not listed (code points below 0x80, overlong forms included, pass
// through as that character). Lead bytes and continuation bytes that only
// build up a sequence produce no output beat, nor do stray continuation bytes
// or bytes 0xF8..0xFF seen outside a sequence. A sequence broken by a
// non-continuation byte, or cut off by a beat flagged as last, gives '?'.
// out_end_of_text copies the last-byte flag of the input beat that caused the
// output. With transliterate_enable (APB address 0, bit 0, reset 1) cleared,
// every byte is forwarded raw and any partial sequence is discarded; change
// it only while the block is idle. Throughput is one byte per clock while the
// output is not stalled: a beat is held in the input register, is decoded there
// by a single pass of combinational logic (table lookup included), and lands in
// the output register. The input register refills whenever it is empty or
// drains in the same cycle.

module utf8_vietnamese_to_ascii (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte stream
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last_byte,
  // output character stream
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_ascii_char,
  output logic             out_end_of_text,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------- configuration ----------------
  logic en_r, en_nxt;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register index is paddr[2]; byte lanes below it are ignored
  always_comb begin
    en_nxt = en_r;
    if (cfg_wr && paddr[2] == u8va_pkg::REG_ENABLE) begin
      en_nxt = pwdata[0];
    end
  end

  assign prdata = (paddr[2] == u8va_pkg::REG_ENABLE) ? {31'b0, en_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
    end else begin
      en_r <= en_nxt;
    end
  end

  // ---------------- output register state ----------------
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_eot_r, out_eot_nxt;

  // ---------------- input register ----------------
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r, s1_byte_nxt;
  logic       s1_last_r, s1_last_nxt;
  logic       s1_adv;
  logic       in_acc;

  // The decode stage advances when the output register can take its result
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    s1_last_nxt  = s1_last_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
      s1_byte_nxt  = in_byte;
      s1_last_nxt  = in_last_byte;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    s1_byte_r <= s1_byte_nxt;
    s1_last_r <= s1_last_nxt;
  end

  // ---------------- decoder state and logic ----------------
  u8va_pkg::dec_state_t  st_r, st_nxt, st_dec;
  u8va_pkg::dec_result_t res;

  u8va_decode u_decode (
    .en        (en_r),
    .byte_in   (s1_byte_r),
    .last      (s1_last_r),
    .state     (st_r),
    .state_nxt (st_dec),
    .result    (res)
  );

  // Commit the decoder state only for the beat that leaves the input register
  assign st_nxt = s1_adv ? st_dec : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_eot_nxt   = out_eot_r;
    if (s1_adv) begin
      // load a result, or go empty on a beat that drops
      out_valid_nxt = res.emit;
      out_char_nxt  = res.ch;
      out_eot_nxt   = s1_last_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_char_r <= out_char_nxt;
    out_eot_r  <= out_eot_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ascii_char  = out_char_r;
  assign out_end_of_text = out_eot_r;

  // ---------------- assertions ----------------
  // No sequence pending means the accumulator was cleared
  a_idle_accum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pend == '0 |-> st_r.accum == '0)
    else $error("accumulator nonzero with no sequence pending");

  // A stalled output holds the byte in the input register
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |=> s1_valid_r && $stable(s1_byte_r))
    else $error("input register lost a beat under output stall");

  // A disabled beat leaves no sequence pending
  a_disable_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !en_r |=> st_r.pend == '0)
    else $error("sequence left pending after a pass-through beat");

  // A beat flagged as last always leaves the decoder idle
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> st_r.pend == '0)
    else $error("sequence left pending after the last byte");

  // A beat taken with one continuation byte pending always shows up at the output
  a_cont_emits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && en_r && st_r.pend == u8va_pkg::PEND_W'(1) |=> out_valid_r)
    else $error("final byte of a sequence produced no output");

endmodule

`default_nettype wire

/* bench/tb_utf8_vietnamese_to_ascii.sv */
// Self-checking bench for the UTF-8 to ASCII transliterator.
// Scoreboard class models the decoder; plain tasks drive the byte stream and APB port.
// Depends on u8va_pkg and the utf8_vietnamese_to_ascii RTL.
`timescale 1ns / 1ps

module tb_utf8_vietnamese_to_ascii;

  // Cycles to let the two-stage pipeline settle once nothing is expected any more
  localparam int DRAIN_CYCLES = 6;
  localparam logic [2:0] ENABLE_ADDR = 3'(4 * int'(u8va_pkg::REG_ENABLE));

  // Opening text, {last, byte}: extremes, each decode path, each corner case
  localparam logic [8:0] OPENING_TEXT [25] = '{
    9'h000, 9'h07F,                     // ASCII extremes pass through
    9'h0C4, 9'h091,                     // two-byte letter
    9'h0E2, 9'h080, 9'h0A6,             // three-byte ellipsis
    9'h0F0, 9'h09F, 9'h098, 9'h080,     // four-byte point above 16 bits
    9'h080,                             // stray continuation, dropped
    9'h0FF,                             // invalid lead, dropped
    9'h0C3, 9'h041,                     // sequence broken by ASCII
    9'h0C1, 9'h081,                     // overlong form of an ASCII letter
    9'h0E1, 9'h1BB,                     // cut short on a continuation
    9'h1C3,                             // cut short on the lead itself
    9'h1BF,                             // dropped byte carrying the last flag
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF      // widest code point
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } char_beat_t;

  // Models the decoder and holds the characters still owed by the block
  class translit_board;
    logic                      enable;
    logic [1:0]                pend;
    logic [u8va_pkg::CP_W-1:0] accum;
    char_beat_t                expected_chars[$];
    int                        errors;

    function new();
      enable = 1'b1;
      pend   = '0;
      accum  = '0;
      errors = 0;
    endfunction

    function void set_enable(logic value);
      enable = value;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void push_char(logic [7:0] ch, logic eot);
      char_beat_t beat;
      beat.ch  = ch;
      beat.eot = eot;
      expected_chars.push_back(beat);
    endfunction

    // Transliteration of a complete code point
    function logic [7:0] lookup_char(logic [u8va_pkg::CP_W-1:0] cp);
      if (cp < u8va_pkg::CP_W'(u8va_pkg::ASCII_LIMIT)) return cp[7:0];
      case (cp)
        21'h0110: return "D";
        21'h0111: return "d";
        21'h00C0, 21'h00C1, 21'h00C2, 21'h00C3, 21'h0102,
        21'h1EA0, 21'h1EA2, 21'h1EA4, 21'h1EA6, 21'h1EA8, 21'h1EAA, 21'h1EAC,
        21'h1EAE, 21'h1EB0, 21'h1EB2, 21'h1EB4, 21'h1EB6: return "A";
        21'h00E0, 21'h00E1, 21'h00E2, 21'h00E3, 21'h0103,
        21'h1EA1, 21'h1EA3, 21'h1EA5, 21'h1EA7, 21'h1EA9, 21'h1EAB, 21'h1EAD,
        21'h1EAF, 21'h1EB1, 21'h1EB3, 21'h1EB5, 21'h1EB7: return "a";
        21'h00C8, 21'h00C9, 21'h00CA,
        21'h1EB8, 21'h1EBA, 21'h1EBC, 21'h1EBE, 21'h1EC0, 21'h1EC2, 21'h1EC4,
        21'h1EC6: return "E";
        21'h00E8, 21'h00E9, 21'h00EA,
        21'h1EB9, 21'h1EBB, 21'h1EBD, 21'h1EBF, 21'h1EC1, 21'h1EC3, 21'h1EC5,
        21'h1EC7: return "e";
        21'h00CC, 21'h00CD, 21'h0128, 21'h1EC8, 21'h1ECA: return "I";
        21'h00EC, 21'h00ED, 21'h0129, 21'h1EC9, 21'h1ECB: return "i";
        21'h00D2, 21'h00D3, 21'h00D4, 21'h00D5, 21'h01A0,
        21'h1ECC, 21'h1ECE, 21'h1ED0, 21'h1ED2, 21'h1ED4, 21'h1ED6, 21'h1ED8,
        21'h1EDA, 21'h1EDC, 21'h1EDE, 21'h1EE0, 21'h1EE2: return "O";
        21'h00F2, 21'h00F3, 21'h00F4, 21'h00F5, 21'h01A1, 21'h00B0, 21'h00BA,
        21'h1ECD, 21'h1ECF, 21'h1ED1, 21'h1ED3, 21'h1ED5, 21'h1ED7, 21'h1ED9,
        21'h1EDB, 21'h1EDD, 21'h1EDF, 21'h1EE1, 21'h1EE3: return "o";
        21'h00D9, 21'h00DA, 21'h0168, 21'h01AF,
        21'h1EE4, 21'h1EE6, 21'h1EE8, 21'h1EEA, 21'h1EEC, 21'h1EEE,
        21'h1EF0: return "U";
        21'h00F9, 21'h00FA, 21'h0169, 21'h01B0, 21'h00B5, 21'h03BC,
        21'h1EE5, 21'h1EE7, 21'h1EE9, 21'h1EEB, 21'h1EED, 21'h1EEF,
        21'h1EF1: return "u";
        21'h00DD, 21'h1EF2, 21'h1EF4, 21'h1EF6, 21'h1EF8: return "Y";
        21'h00FD, 21'h1EF3, 21'h1EF5, 21'h1EF7, 21'h1EF9: return "y";
        21'h2103: return "C";
        21'h2109: return "F";
        21'h00D7: return "x";
        21'h00F7: return "/";
        21'h2190: return "<";
        21'h2192: return ">";
        21'h2013, 21'h2014: return "-";
        21'h2018, 21'h2019: return "'";
        21'h201C, 21'h201D: return "\"";
        21'h2026: return ".";
        default: return u8va_pkg::UNKNOWN_CHAR;
      endcase
    endfunction

    // Advance the decoder by one accepted input beat
    function void note_byte(logic [7:0] b, logic last);
      logic [1:0]                need;
      logic [u8va_pkg::CP_W-1:0] seed;
      if (!enable) begin
        pend  = '0;
        accum = '0;
        push_char(b, last);
        return;
      end
      if (pend == 2'd0) begin
        if (b < u8va_pkg::ASCII_LIMIT) begin
          push_char(b, last);
          return;
        end
        if ((b & u8va_pkg::LEAD2_MASK) == u8va_pkg::LEAD2_CODE) begin
          need = 2'd1;
          seed = u8va_pkg::CP_W'(b[4:0]);
        end else if ((b & u8va_pkg::LEAD3_MASK) == u8va_pkg::LEAD3_CODE) begin
          need = 2'd2;
          seed = u8va_pkg::CP_W'(b[3:0]);
        end else if ((b & u8va_pkg::LEAD4_MASK) == u8va_pkg::LEAD4_CODE) begin
          need = 2'd3;
          seed = u8va_pkg::CP_W'(b[2:0]);
        end else begin
          return;  // stray continuation or invalid lead
        end
        if (last) begin
          accum = '0;
          push_char(u8va_pkg::UNKNOWN_CHAR, last);
          return;
        end
        pend  = need;
        accum = seed;
        return;
      end
      if ((b & u8va_pkg::CONT_MASK) != u8va_pkg::CONT_CODE) begin
        pend  = '0;
        accum = '0;
        push_char(u8va_pkg::UNKNOWN_CHAR, last);
        return;
      end
      accum = {accum[u8va_pkg::CP_W-7:0], b[5:0]};
      pend  = pend - 2'd1;
      if (pend == 2'd0) begin
        push_char(lookup_char(accum), last);
        accum = '0;
      end else if (last) begin
        pend  = '0;
        accum = '0;
        push_char(u8va_pkg::UNKNOWN_CHAR, last);
      end
    endfunction

    // Compare one output beat with the oldest owed character
    function void check_char(logic [7:0] ch, logic eot);
      char_beat_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected output beat char=%h eot=%b", $time, ch, eot);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: char mismatch expected=%h actual=%h", $time, want.ch, ch);
        errors++;
      end
      if (eot !== want.eot) begin
        $display("%0t: end_of_text mismatch expected=%b actual=%b", $time, want.eot, eot);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_ascii_char;
  logic        out_end_of_text;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  translit_board board;
  int send_idle_pct;
  int stall_pct;
  int bytes_sent;

  utf8_vietnamese_to_ascii dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ascii_char (out_ascii_char),
    .out_end_of_text(out_end_of_text),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: stall at random, re-decided every cycle on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every output beat taken at a rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_char(out_ascii_char, out_end_of_text);
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #400_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic rand_last();
    return ($urandom_range(99) < 4);
  endfunction

  // Code points weighted toward the dense parts of the transliteration map
  function automatic int unsigned pick_code_point();
    case ($urandom_range(9))
      0, 1:    return $urandom_range(32'h1FF, 32'h80);
      2, 3, 4: return $urandom_range(32'h1EF9, 32'h1EA0);
      5:       return $urandom_range(32'h2030, 32'h2010);
      6:       return $urandom_range(32'h2195, 32'h2100);
      7:       return $urandom_range(32'h7F, 32'h0);
      8:       return $urandom_range(32'h10FFFF, 32'h0);
      default: return $urandom_range(32'h1FFFFF, 32'h0);
    endcase
  endfunction

  // Shortest multi-byte length, sometimes stretched to an overlong form
  function automatic int code_len(int unsigned cp);
    int len;
    if (cp < 32'h800) len = 2;
    else if (cp < 32'h10000) len = 3;
    else len = 4;
    if (len < 4 && $urandom_range(99) < 15) len++;
    return len;
  endfunction

  function automatic void encode_cp(input int unsigned cp, input int len,
                                    output logic [7:0] seq [4]);
    logic [20:0] v;
    v = cp[20:0];
    seq[1] = u8va_pkg::CONT_CODE | 8'(v[5:0]);
    seq[2] = u8va_pkg::CONT_CODE | 8'(v[5:0]);
    seq[3] = u8va_pkg::CONT_CODE | 8'(v[5:0]);
    case (len)
      2: begin
        seq[0] = u8va_pkg::LEAD2_CODE | 8'(v[10:6]);
      end
      3: begin
        seq[0] = u8va_pkg::LEAD3_CODE | 8'(v[15:12]);
        seq[1] = u8va_pkg::CONT_CODE | 8'(v[11:6]);
      end
      default: begin
        seq[0] = u8va_pkg::LEAD4_CODE | 8'(v[20:18]);
        seq[1] = u8va_pkg::CONT_CODE | 8'(v[17:12]);
        seq[2] = u8va_pkg::CONT_CODE | 8'(v[11:6]);
      end
    endcase
  endfunction

  // Drive one byte; hold it until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!(in_valid && in_ready));
    board.note_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed character is out
  task automatic drain_pause();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
  endtask

  // Write the enable register while the block is idle, then read it back
  task automatic write_enable(input logic value);
    logic [31:0] rd;
    drain_pause();
    // a partial sequence gives no output; let it clear the pipeline anyway
    repeat (DRAIN_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENABLE_ADDR;
    pwdata  <= {31'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_enable(value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[0] !== value) begin
      $display("%0t: enable readback mismatch expected=%b actual=%b", $time, value, rd[0]);
      board.errors++;
    end
  endtask

  // One random piece of text: mostly well-formed, some broken or noise
  task automatic send_text_piece();
    int unsigned kind;
    int unsigned cp;
    int          len;
    int          cut;
    logic [7:0]  seq [4];
    logic [7:0]  breaker;
    kind = $urandom_range(99);
    cp   = pick_code_point();
    len  = code_len(cp);
    encode_cp(cp, len, seq);
    if (kind < 35) begin
      send_byte(8'($urandom_range(127)), rand_last());
    end else if (kind < 80) begin
      for (int i = 0; i < len; i++) send_byte(seq[i], (i == len - 1) ? rand_last() : 1'b0);
    end else if (kind < 87) begin
      // break the sequence with anything that is not a continuation byte
      cut = $urandom_range(len - 1, 1);
      for (int i = 0; i < cut; i++) send_byte(seq[i], 1'b0);
      breaker = 8'($urandom);
      if ((breaker & u8va_pkg::CONT_MASK) == u8va_pkg::CONT_CODE) breaker[6] = 1'b1;
      send_byte(breaker, rand_last());
    end else if (kind < 92) begin
      // cut the sequence short with the last flag
      cut = $urandom_range(len - 1, 1);
      for (int i = 0; i < cut; i++) send_byte(seq[i], i == cut - 1);
    end else if (kind < 96) begin
      if ($urandom_range(1)) send_byte(8'($urandom_range(8'hBF, 8'h80)), rand_last());
      else send_byte(8'($urandom_range(8'hFF, 8'hF8)), rand_last());
    end else begin
      send_byte(8'($urandom), rand_last());
    end
  endtask

  task automatic run_phase(input int n, input int send_pct, input int stall);
    int target;
    int halfway;
    bit paused;
    target  = bytes_sent + n;
    halfway = bytes_sent + n / 2;
    paused  = 1'b0;
    send_idle_pct <= send_pct;
    stall_pct     <= stall;
    while (bytes_sent < target) begin
      send_text_piece();
      // hold the sender now and then until the block has caught up
      if ((!paused && bytes_sent >= halfway) || $urandom_range(99) == 0) begin
        drain_pause();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    board         = new();
    send_idle_pct = 0;
    stall_pct     = 0;
    bytes_sent    = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte       = '0;
    in_last_byte  = 1'b0;
    out_ready     = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // enable still at its reset value here
    foreach (OPENING_TEXT[i]) send_byte(OPENING_TEXT[i][7:0], OPENING_TEXT[i][8]);

    write_enable(1'b0);
    run_phase(150, 0, 0);
    write_enable(1'b1);
    run_phase(250, 0, 0);
    run_phase(250, 48, 0);
    run_phase(250, 0, 48);
    write_enable(1'b0);
    run_phase(100, 10, 10);
    write_enable(1'b1);
    run_phase(150, 10, 10);

    drain_pause();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
